// ===== hdl/sfla_pkg.sv =====
// Shared types and constants for the slab free-list allocator.
package sfla_pkg;

    // Fixed field widths
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 7;
    localparam int DIV_STEPS = ADDR_W;

    // Configuration register indexes
    localparam logic [1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [1:0] REG_SLOT_SIZE  = 2'd1;
    localparam logic [1:0] REG_SLOT_COUNT = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REBUILD = 2'd2,
        OP_NOP     = 2'd3
    } op_e_t;

    // Result selection
    typedef enum logic [1:0] {
        RES_GRANT,
        RES_DONE,
        RES_EMPTY,
        RES_IGNORED
    } res_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC_MUL,
        ST_ALLOC_UPD,
        ST_FREE_MUL,
        ST_FREE_CHK,
        ST_FREE_DIV,
        ST_FREE_PUSH,
        ST_REBUILD,
        ST_DELIVER
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     capture;
        logic     mul;
        logic     ram_rd;
        logic     head_pop;
        logic     push;
        logic     sweep;
        logic     div_start;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_e_t op;
        logic  head_lt_n;
        logic  free_bad;
        logic  quot_ok;
        logic  div_done;
        logic  sweep_last;
        logic  out_free;
    } ctrl_stat_t;

endpackage

// ===== hdl/sfla_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sfla_div.sv =====
// Radix-2 restoring divider: 32-bit dividend by 16-bit divisor, one bit per cycle.
module sfla_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sfla_pkg::ADDR_W-1:0]     dividend,
    input  logic [sfla_pkg::SIZE_W-1:0]     divisor,
    output logic                            done,
    output logic [sfla_pkg::ADDR_W-1:0]     quotient
);
    import sfla_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W:0]   rem_reg, rem_next;
    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [SIZE_W:0]   rem_shift;
    logic              ge;

    // One restoring step: shift in next dividend bit, trial subtract
    always_comb
    begin
        rem_shift = {rem_reg[SIZE_W-1:0], quo_reg[ADDR_W-1]};
        ge        = (rem_shift >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_shift - {1'b0, divisor}) : rem_shift;
            quo_next = {quo_reg[ADDR_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/sfla_ctrl.sv =====
// Controller state machine sequencing allocate, free, rebuild and init sweep.
module sfla_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sfla_pkg::ctrl_stat_t   stat,
    output sfla_pkg::ctrl_cmd_t    cmd
);
    import sfla_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.op)
                    OP_ALLOC:   state_next = stat.head_lt_n ? ST_ALLOC_MUL : ST_DELIVER;
                    OP_FREE:    state_next = ST_FREE_MUL;
                    OP_REBUILD: state_next = ST_REBUILD;
                    default:    state_next = ST_DELIVER;
                endcase
            end
            ST_ALLOC_MUL: state_next = ST_ALLOC_UPD;
            ST_ALLOC_UPD: state_next = ST_DELIVER;
            ST_FREE_MUL:  state_next = ST_FREE_CHK;
            ST_FREE_CHK:  state_next = stat.free_bad ? ST_DELIVER : ST_FREE_DIV;
            ST_FREE_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_FREE_PUSH;
                end
            end
            ST_FREE_PUSH: state_next = ST_DELIVER;
            ST_REBUILD:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECODE:
            begin
                case (stat.op)
                    OP_ALLOC:
                    begin
                        if (!stat.head_lt_n)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_EMPTY;
                        end
                    end
                    OP_FREE, OP_REBUILD:
                    begin
                        cmd.res_load = 1'b0;
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_DONE;
                    end
                endcase
            end
            ST_ALLOC_MUL:
            begin
                cmd.mul    = 1'b1;
                cmd.ram_rd = 1'b1;
            end
            ST_ALLOC_UPD:
            begin
                cmd.head_pop = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_GRANT;
            end
            ST_FREE_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_FREE_CHK:
            begin
                if (stat.free_bad)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_IGNORED;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            ST_FREE_PUSH:
            begin
                cmd.res_load = 1'b1;
                if (stat.quot_ok)
                begin
                    cmd.push    = 1'b1;
                    cmd.res_sel = RES_DONE;
                end
                else
                begin
                    cmd.res_sel = RES_IGNORED;
                end
            end
            ST_REBUILD:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_DONE;
                end
            end
            ST_DELIVER:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/sfla_dp.sv =====
// Datapath: config registers, list head, next-slot RAM, multiplier, divider, result registers.
module sfla_dp #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [1:0]                       cfg_index,
    input  logic [sfla_pkg::ADDR_W-1:0]      cfg_data,
    input  logic [1:0]                       operation,
    input  logic [sfla_pkg::ADDR_W-1:0]      address,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [sfla_pkg::ADDR_W-1:0]      granted_address,
    output logic [1:0]                       status,
    input  sfla_pkg::ctrl_cmd_t              cmd,
    output sfla_pkg::ctrl_stat_t             stat
);
    import sfla_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SLOTS + 1);
    localparam int AW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PROD_W = IDX_W + SIZE_W;

    logic [ADDR_W-1:0]  pool_base_reg;
    logic [SIZE_W-1:0]  slot_size_reg;
    logic [COUNT_W-1:0] slot_count_reg;

    op_e_t              op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   sweep_cnt_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [1:0]         res_status_reg;
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [1:0]         out_status_reg;

    logic [IDX_W-1:0]   live_n;
    logic [IDX_W-1:0]   mul_a;
    logic [ADDR_W-1:0]  grant_sum;
    logic [ADDR_W:0]    pool_hi;
    logic               sweep_last;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [IDX_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]   ram_rdata;
    logic               div_done;
    logic [ADDR_W-1:0]  quotient;

    // Effective slot count, clamped to the pool capacity
    always_comb
    begin
        if (32'(slot_count_reg) > 32'(MAX_SLOTS))
        begin
            live_n = IDX_W'(MAX_SLOTS);
        end
        else
        begin
            live_n = IDX_W'(slot_count_reg);
        end
    end

    // Shared multiplier operand and address arithmetic
    assign mul_a      = (op_reg == OP_ALLOC) ? head_reg : live_n;
    assign grant_sum  = pool_base_reg + ADDR_W'(prod_reg);
    assign pool_hi    = {1'b0, pool_base_reg} + (ADDR_W + 1)'(prod_reg);
    assign sweep_last = (sweep_cnt_reg == IDX_W'(MAX_SLOTS - 1));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= '0;
            slot_size_reg  <= SIZE_W'(256);
            slot_count_reg <= COUNT_W'(64);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_POOL_BASE:  pool_base_reg  <= cfg_data;
                REG_SLOT_SIZE:  slot_size_reg  <= cfg_data[SIZE_W-1:0];
                REG_SLOT_COUNT: slot_count_reg <= cfg_data[COUNT_W-1:0];
                default:        pool_base_reg  <= pool_base_reg;
            endcase
        end
    end

    // Input capture and product register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_e_t'(operation);
            addr_reg <= address;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(slot_size_reg);
        end
    end

    // List head and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.sweep)
            begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + IDX_W'(1);
            end
            if (cmd.sweep && sweep_last)
            begin
                head_reg <= '0;
            end
            else if (cmd.head_pop)
            begin
                head_reg <= ram_rdata;
            end
            else if (cmd.push)
            begin
                head_reg <= quotient[IDX_W-1:0];
            end
        end
    end

    // Next-slot RAM: sweep writes i+1, push links freed slot to old head
    assign ram_we    = cmd.sweep || cmd.push;
    assign ram_waddr = cmd.sweep ? sweep_cnt_reg[AW-1:0] : quotient[AW-1:0];
    assign ram_wdata = cmd.sweep ? (sweep_cnt_reg + IDX_W'(1)) : head_reg;

    sfla_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_next_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_rd),
        .raddr (head_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Slot index of a freed address
    sfla_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (addr_reg - pool_base_reg),
        .divisor  (slot_size_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Pending result
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_addr_reg <= (cmd.res_sel == RES_GRANT) ? grant_sum : '0;
            case (cmd.res_sel)
                RES_EMPTY:   res_status_reg <= STATUS_EMPTY;
                RES_IGNORED: res_status_reg <= STATUS_IGNORED;
                default:     res_status_reg <= STATUS_DONE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign status          = out_status_reg;

    // Status to controller
    always_comb
    begin
        stat            = '0;
        stat.op         = op_reg;
        stat.head_lt_n  = (head_reg < live_n);
        stat.free_bad   = (addr_reg == '0) || (addr_reg < pool_base_reg)
                          || ({1'b0, addr_reg} >= pool_hi) || (slot_size_reg == '0);
        stat.quot_ok    = (quotient < ADDR_W'(live_n));
        stat.div_done   = div_done;
        stat.sweep_last = sweep_last;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Sweep counter is back at zero whenever a new item comes in
    a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (sweep_cnt_reg == '0))
        else $error("sweep counter not idle at transfer");

    // Only a live head slot is ever looked up
    a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_rd |-> stat.head_lt_n)
        else $error("next-slot read of a slot outside the list");

    // Output valid rises only from a result load
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("output valid without result load");

    // Delivered status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg == STATUS_DONE || out_status_reg == STATUS_EMPTY
                           || out_status_reg == STATUS_IGNORED))
        else $error("undefined status code");

endmodule

// ===== hdl/slab_free_list_allocator_core.sv =====
// Slab free-list allocator top level: controller plus datapath.
//
// Input channel (in_valid/in_ready) carries operation and address; each
// transfer produces exactly one result on the output channel
// (out_valid/out_ready) with granted_address and status. One item is in
// work at a time; in_ready is high while the controller is idle, even
// when the last result still sits unclaimed in the output register.
// Steps from input transfer to out_valid: allocate reads the head's link
// from the RAM and does one multiply; allocate on an empty list and no-op
// go straight to delivery; free does a bounds check, then a 32-step serial
// divider; a free that fails the bounds check stops there; rebuild writes
// one next-slot entry per cycle. in_ready rises together with out_valid.
// After reset the controller sweeps the next-slot RAM before in_ready
// first goes high; configuration writes are taken then too.
// If the receiver stalls, a finished result waits in the output stage and
// the controller holds the following result until that slot frees up.
// Configuration (cfg_write, cfg_index, cfg_data) takes effect at the edge
// where cfg_write is high and should be used only while the block is idle.
module slab_free_list_allocator_core #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [1:0]                   cfg_index,
    input  logic [sfla_pkg::ADDR_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   operation,
    input  logic [sfla_pkg::ADDR_W-1:0]  address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sfla_pkg::ADDR_W-1:0]  granted_address,
    output logic [1:0]                   status
);
    import sfla_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // Sequencer
    sfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    sfla_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .operation       (operation),
        .address         (address),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .granted_address (granted_address),
        .status          (status),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

// ===== verif/slab_free_list_allocator_core_tb.sv =====
// Testbench for the slab free-list allocator: directed and random pool traffic.
`timescale 1ns / 1ps

module testbench;
    import sfla_pkg::*;

    localparam int          MAX_SLOTS   = 64;
    localparam int          MAX_SHOWN   = 10;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;
    localparam int          DRAIN_CYCLES = MAX_SLOTS + 16;

    typedef struct packed {
        logic [ADDR_W-1:0] grant;
        logic [1:0]        status;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [1:0]          cfg_index = REG_POOL_BASE;
    logic [ADDR_W-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          operation = OP_NOP;
    logic [ADDR_W-1:0]   address = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [ADDR_W-1:0]   granted_address;
    logic [1:0]          status;

    // Shadow copy of the registers and the free list
    logic [ADDR_W-1:0]   cfg_base;
    logic [SIZE_W-1:0]   cfg_size;
    logic [COUNT_W-1:0]  cfg_count;
    logic [COUNT_W-1:0]  free_head;
    logic [COUNT_W-1:0]  free_link [MAX_SLOTS];

    outcome_t            pending_outcomes [$];
    int                  mismatches = 0;
    int                  sent_items = 0;
    int                  send_idle_pct = 14;
    int                  recv_stall_pct = 67;

    slab_free_list_allocator_core #(
        .MAX_SLOTS (MAX_SLOTS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .address         (address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted_address (granted_address),
        .status          (status)
    );

    always #5 clk = ~clk;

    // Run limit, far above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL slab_free_list_allocator_core");
        $finish;
    end

    function automatic logic [COUNT_W-1:0] live_slots();
        return (cfg_count > MAX_SLOTS) ? COUNT_W'(MAX_SLOTS) : cfg_count;
    endfunction

    function automatic logic [63:0] pool_end();
        return 64'(cfg_base) + 64'(cfg_size) * 64'(live_slots());
    endfunction

    task automatic thread_free_list();
        free_head = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
            free_link[i] = COUNT_W'(i + 1);
    endtask

    // Expected outcome of one operation; updates the shadow free list
    task automatic apply_pool_op(input op_e_t op, input logic [ADDR_W-1:0] addr,
                                 output outcome_t res);
        logic [COUNT_W-1:0] n;
        logic [63:0]        lo;
        logic [63:0]        hi;
        logic [63:0]        slot_addr;
        logic [63:0]        slot;
        n = live_slots();
        res.grant = '0;
        res.status = STATUS_DONE;
        case (op)
            OP_ALLOC:
            begin
                if (free_head < n)
                begin
                    slot_addr = 64'(cfg_base) + 64'(free_head) * 64'(cfg_size);
                    res.grant = slot_addr[ADDR_W-1:0];
                    free_head = free_link[free_head[5:0]];
                end
                else
                    res.status = STATUS_EMPTY;
            end
            OP_FREE:
            begin
                lo = 64'(cfg_base);
                hi = pool_end();
                if (addr == 0 || 64'(addr) < lo || 64'(addr) >= hi || cfg_size == 0)
                    res.status = STATUS_IGNORED;
                else
                begin
                    slot = (64'(addr) - lo) / 64'(cfg_size);
                    if (slot < 64'(n))
                    begin
                        free_link[slot[5:0]] = free_head;
                        free_head = COUNT_W'(slot);
                    end
                    else
                        res.status = STATUS_IGNORED;
                end
            end
            OP_REBUILD:
                thread_free_list();
            default: ;
        endcase
    endtask

    // Receiver: random stalls per cycle
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                if (mismatches < MAX_SHOWN)
                    $display("unexpected result: grant %h status %0d",
                             granted_address, status);
                mismatches++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (granted_address !== want.grant || status !== want.status)
                begin
                    if (mismatches < MAX_SHOWN)
                        $display("mismatch: grant exp %h got %h, status exp %0d got %0d",
                                 want.grant, granted_address, want.status, status);
                    mismatches++;
                end
            end
        end
    end

    // One input transfer; entered and left at a falling edge
    task automatic send_op(input op_e_t op, input logic [ADDR_W-1:0] addr);
        outcome_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        operation = op;
        address = addr;
        do
            @(posedge clk);
        while (!in_ready);
        apply_pool_op(op, addr, res);
        pending_outcomes.push_back(res);
        sent_items++;
        @(negedge clk);
    endtask

    // Block idle: no transfer pending and controller ready
    task automatic wait_idle();
        in_valid = 1'b0;
        @(negedge clk);
        while (pending_outcomes.size() != 0 || !in_ready)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_POOL_BASE:  cfg_base = data;
            REG_SLOT_SIZE:  cfg_size = data[SIZE_W-1:0];
            REG_SLOT_COUNT: cfg_count = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_basic_ops();
        send_op(OP_ALLOC, '0);
        send_op(OP_ALLOC, '1);
        send_op(OP_FREE, 32'h0000_0000);
        // misaligned pointer rounds down to its slot
        send_op(OP_FREE, 32'h0000_0111);
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, 32'hFFFF_FFFF);
        send_op(OP_FREE, 32'h0000_3FFF);
        send_op(OP_ALLOC, '0);
        send_op(OP_NOP, 32'hFFFF_FFFF);
        send_op(OP_REBUILD, 32'h5A5A_A5A5);
        send_op(OP_ALLOC, '0);
        wait_idle();
    endtask

    task automatic test_empty_pool();
        write_reg(REG_SLOT_COUNT, 32'd2);
        send_op(OP_REBUILD, '0);
        repeat (3)
            send_op(OP_ALLOC, '0);
        wait_idle();
        write_reg(REG_SLOT_COUNT, 32'd0);
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, 32'h0000_0010);
        wait_idle();
        // count above the slot limit, list kept without rebuild
        write_reg(REG_SLOT_COUNT, 32'd127);
        send_op(OP_ALLOC, '0);
        wait_idle();
    endtask

    task automatic test_zero_slot_size();
        write_reg(REG_POOL_BASE, 32'h1234_5678);
        write_reg(REG_SLOT_SIZE, 32'd0);
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, 32'h1234_5678);
        wait_idle();
    endtask

    task automatic test_wrapping_pool();
        write_reg(REG_POOL_BASE, 32'hFFFF_FF00);
        write_reg(REG_SLOT_SIZE, 32'h0000_FFFF);
        write_reg(REG_SLOT_COUNT, 32'd64);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        send_op(OP_REBUILD, '0);
        send_op(OP_ALLOC, '0);
        send_op(OP_ALLOC, '0);
        send_op(OP_FREE, 32'hFFFF_FFFF);
        send_op(OP_ALLOC, '0);
        wait_idle();
    endtask

    // Address inside the pool, aligned or not; a random one if the pool has no slots or a zero slot size
    function automatic logic [ADDR_W-1:0] pool_address();
        logic [63:0] off;
        logic [63:0] a;
        if (cfg_size == 0 || live_slots() == 0)
            return $urandom;
        off = 64'($urandom_range(int'(live_slots()) - 1)) * 64'(cfg_size);
        if ($urandom_range(1))
            off += 64'($urandom_range(int'(cfg_size) - 1));
        a = 64'(cfg_base) + off;
        return (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[ADDR_W-1:0];
    endfunction

    // Addresses at and past the pool edges
    function automatic logic [ADDR_W-1:0] stray_address();
        logic [63:0] hi;
        hi = pool_end();
        case ($urandom_range(4))
            0: return 32'h0000_0000;
            1: return cfg_base - 32'd1;
            2: return hi[ADDR_W-1:0];
            3: return hi[ADDR_W-1:0] - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_config();
        logic [ADDR_W-1:0] data;
        case ($urandom_range(5))
            0: data = 32'h0000_0000;
            1: data = 32'hFFFF_FFFF;
            2: data = 32'hFFFF_0000 | $urandom_range(16'hFFFF);
            default: data = $urandom;
        endcase
        write_reg(REG_POOL_BASE, data);
        data = $urandom;
        case ($urandom_range(7))
            0: data[15:0] = 16'd0;
            1: data[15:0] = 16'd1;
            2: data[15:0] = 16'hFFFF;
            3: data[15:0] = 16'd256;
            default: data[15:0] = 16'($urandom_range(1, 16'hFFFF));
        endcase
        write_reg(REG_SLOT_SIZE, data);
        data = $urandom;
        case ($urandom_range(5))
            0: data[6:0] = 7'd0;
            1: data[6:0] = 7'd1;
            2: data[6:0] = 7'($urandom_range(2, 8));
            3: data[6:0] = 7'd64;
            4: data[6:0] = 7'($urandom_range(65, 127));
            default: data[6:0] = 7'($urandom_range(9, 63));
        endcase
        write_reg(REG_SLOT_COUNT, data);
        if ($urandom_range(9) == 0)
            write_reg(REG_UNUSED, $urandom);
    endtask

    task automatic test_random(input int target);
        int goal;
        int burst;
        int pick;
        goal = sent_items + target;
        while (sent_items < goal)
        begin
            pick_config();
            if ($urandom_range(1))
                send_op(OP_REBUILD, $urandom);
            burst = $urandom_range(20, 80);
            repeat (burst)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    send_op(OP_ALLOC, $urandom);
                else if (pick < 85)
                    send_op(OP_FREE, pool_address());
                else if (pick < 91)
                    send_op(OP_FREE, stray_address());
                else if (pick < 95)
                    send_op(OP_REBUILD, $urandom);
                else
                    send_op(OP_NOP, $urandom);
            end
            wait_idle();
        end
    endtask

    initial
    begin
        cfg_base = '0;
        cfg_size = SIZE_W'(256);
        cfg_count = COUNT_W'(64);
        thread_free_list();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        wait_idle();

        test_basic_ops();
        test_empty_pool();
        test_zero_slot_size();
        test_wrapping_pool();
        test_random(410);

        send_idle_pct = 67;
        recv_stall_pct = 14;
        test_random(410);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(410);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_outcomes.size() != 0)
            $display("%0d results never arrived", pending_outcomes.size());
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("PASS slab_free_list_allocator_core");
        else
            $display("FAIL slab_free_list_allocator_core");
        $finish;
    end

endmodule
